// ===== rtl/mpk_pkg.sv =====
// ----------------------------------------------------------------------------
// mpk_pkg
// Shared types, constants and saturating arithmetic for the multipole kick.
// ----------------------------------------------------------------------------
package mpk_pkg;

   localparam int VW = 48;             // value width, Q16.32
   localparam int FRAC = 32;           // fraction bits
   localparam int PW = 2 * VW;         // exact product width
   localparam int HW = VW / 2;         // multiplier slice width
   localparam int LW = 47;             // element length width

   localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

   typedef logic signed [VW-1:0] value_type;

   typedef struct packed {
      value_type n;
      value_type s;
   } coef_pair_type;

   typedef enum logic [1:0] {
      CSR_ORDER  = 2'd0,
      CSR_LENGTH = 2'd1,
      CSR_HBEND  = 2'd2,
      CSR_VBEND  = 2'd3
   } csr_index_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_KICK  = 1'b1;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_LO,
      MUL_HI,
      MUL_DONE
   } mul_phase_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_LOAD,
      ST_H_M1, ST_H_M2, ST_H_M3, ST_H_M4, ST_H_ADD1, ST_H_ADD2,
      ST_F_KX, ST_F_KY,
      ST_C_B1, ST_C_A1,
      ST_C_HXM, ST_C_HXD, ST_C_HYM, ST_C_HYD,
      ST_C_TXM1, ST_C_TXM2, ST_C_TXA, ST_C_TXB, ST_C_TXC,
      ST_C_TYM1, ST_C_TYM2, ST_C_TYA, ST_C_TYB, ST_C_TYC,
      ST_S_D, ST_S_M1, ST_S_M2, ST_S_M3,
      ST_OUT
   } state_type;

   function automatic value_type sadd(value_type a, value_type b);
      logic signed [VW:0] sum;
      sum = {a[VW-1], a} + {b[VW-1], b};
      if (sum[VW] != sum[VW-1]) begin
         return sum[VW] ? value_type'(VMIN) : value_type'(VMAX);
      end
      return sum[VW-1:0];
   endfunction

   function automatic value_type ssub(value_type a, value_type b);
      logic signed [VW:0] dif;
      dif = {a[VW-1], a} - {b[VW-1], b};
      if (dif[VW] != dif[VW-1]) begin
         return dif[VW] ? value_type'(VMIN) : value_type'(VMAX);
      end
      return dif[VW-1:0];
   endfunction

   function automatic value_type sneg(value_type a);
      if (a == value_type'(VMIN)) begin
         return value_type'(VMAX);
      end
      return -a;
   endfunction

   function automatic logic [VW-1:0] mag(value_type a);
      return a[VW-1] ? (~a + 1'b1) : a;
   endfunction

   // Apply sign to a magnitude and saturate; big marks a magnitude >= 2^(VW-1).
   function automatic value_type sfinish(logic neg, logic big, logic [VW-1:0] q);
      if (neg) begin
         return big ? value_type'(VMIN) : value_type'(~q + 1'b1);
      end
      return big ? value_type'(VMAX) : value_type'(q);
   endfunction

endpackage

// ===== rtl/multipole_kick_horner.sv =====
// ----------------------------------------------------------------------------
// multipole_kick_horner
// Thin multipole kick on a particle stream, signed Q16.32 with saturation.
// ----------------------------------------------------------------------------
// A coefficient-write item (tuser 0) stores one normal/skew pair at its accept
// and gives no result. A kick item (tuser 1) takes one item at a time: the
// coefficient pairs travel up a row of cells, one order per Horner step, and
// all products go through one shared multiplier. For multipole order N a kick
// keeps the input closed from its accept until its output step: one load step,
// N Horner steps of four products and two add steps each, two scaling products
// and the output step. With a nonzero element length two quotients through the
// one-bit-per-cycle divider (96 steps each) and the curvature and sigma terms
// come before the output step. The output cycle stretches while the previous
// result is not yet taken. A finished result waits in the output register while
// the next item is taken. Coefficients never written read as undefined.
// ----------------------------------------------------------------------------
module multipole_kick_horner #(
   parameter int MAX_ORDER = 15
) (
   input  logic         clock,
   input  logic         reset,
   // coef_index, coef_normal, coef_skew, particle_id, pos_x, pos_y,
   // momentum_dev, charge_ratio, velocity_ratio, zero pad (lowest first)
   input  logic [359:0] req_tdata,
   input  logic         req_tuser,   // operation
   input  logic         req_tvalid,
   output logic         req_tready,
   // out_id, kick_px, kick_py, sigma_change (lowest first)
   output logic [159:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [47:0]  csr_wdata
);

   localparam int VW    = mpk_pkg::VW;
   localparam int DEPTH = MAX_ORDER + 1;
   localparam int IW    = (MAX_ORDER > 0) ? $clog2(DEPTH) : 1;
   // input field offsets in req_tdata
   localparam int O_NRM = 4;
   localparam int O_SKW = O_NRM + VW;
   localparam int O_ID  = O_SKW + VW;
   localparam int O_X   = O_ID + 16;
   localparam int O_Y   = O_X + VW;
   localparam int O_DL  = O_Y + VW;
   localparam int O_CHI = O_DL + VW;
   localparam int O_RVV = O_CHI + VW;

   typedef mpk_pkg::value_type value_type;

   // configuration
   logic [3:0]            order_ff;
   logic [mpk_pkg::LW-1:0] len_ff;
   value_type             hxl_ff, hyl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= '0;
         len_ff   <= '0;
         hxl_ff   <= '0;
         hyl_ff   <= '0;
      end else if (csr_we) begin
         unique case (mpk_pkg::csr_index_type'(csr_addr))
            mpk_pkg::CSR_ORDER:  order_ff <= csr_wdata[3:0];
            mpk_pkg::CSR_LENGTH: len_ff   <= csr_wdata[mpk_pkg::LW-1:0];
            mpk_pkg::CSR_HBEND:  hxl_ff   <= csr_wdata;
            mpk_pkg::CSR_VBEND:  hyl_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   mpk_pkg::state_type state_ff, state_in;
   logic req_acc, wr_acc, kick_acc;
   assign req_tready = (state_ff == mpk_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign wr_acc     = req_acc && (req_tuser == mpk_pkg::OP_WRITE);
   assign kick_acc   = req_acc && (req_tuser == mpk_pkg::OP_KICK);

   // clamp the order to the table
   logic [IW-1:0] ord_clamp;
   assign ord_clamp = (32'(order_ff) > MAX_ORDER) ? IW'(MAX_ORDER) : IW'(order_ff);

   // row of coefficient cells
   logic cell_load, cell_shift;
   mpk_pkg::coef_pair_type stored [DEPTH];
   mpk_pkg::coef_pair_type travel [DEPTH];
   mpk_pkg::coef_pair_type wr_pair, tap;
   logic [IW-1:0] ord_ff, cnt_ff;

   assign wr_pair.n = req_tdata[O_NRM +: VW];
   assign wr_pair.s = req_tdata[O_SKW +: VW];

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      mpk_pkg::coef_pair_type prev;
      if (k == 0) begin : g_first
         assign prev = '0;
      end else begin : g_next
         assign prev = travel[k-1];
      end
      mpk_cell u_cell (
         .clock       (clock),
         .wr_en       (wr_acc && (32'(req_tdata[3:0]) == k)),
         .wr_pair     (wr_pair),
         .load        (cell_load),
         .shift       (cell_shift),
         .travel_prev (prev),
         .stored      (stored[k]),
         .travel      (travel[k])
      );
   end

   // the pair of the current Horner order sits at the cell of the top order
   assign tap = travel[ord_ff];

   // particle and working registers
   value_type x_ff, y_ff, dl_ff, chi_ff, rvv_ff;
   value_type bx_ff, by_ff, m1_ff, m2_ff, m3_ff, m4_ff;
   value_type r1_ff, r2_ff, hxx_ff, hyy_ff, sig_ff;
   logic [15:0] id_ff;
   logic issued_ff;

   // shared units
   logic      mul_go, mul_done, mul_neg, div_go, div_done;
   value_type mul_a, mul_b, mul_res, div_res, len_val;
   logic [mpk_pkg::PW-1:0] mul_prod;

   assign len_val = {1'b0, len_ff};

   mpk_mul u_mul (
      .clock (clock), .reset (reset), .go (mul_go), .a (mul_a), .b (mul_b),
      .done (mul_done), .res (mul_res), .prod (mul_prod), .neg (mul_neg)
   );

   mpk_div u_div (
      .clock (clock), .reset (reset), .go (div_go), .dividend (mul_prod),
      .neg (mul_neg), .divisor (len_ff), .done (div_done), .res (div_res)
   );

   logic is_mul, is_div, has_len;
   assign has_len = (len_ff != '0);

   // sequencer: operand select and next state
   always_comb begin
      state_in   = state_ff;
      is_mul     = 1'b0;
      is_div     = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      cell_load  = 1'b0;
      cell_shift = 1'b0;
      unique case (state_ff)
         mpk_pkg::ST_IDLE: begin
            cell_load = kick_acc;
            if (kick_acc) state_in = mpk_pkg::ST_LOAD;
         end
         mpk_pkg::ST_LOAD: begin
            cell_shift = 1'b1;
            state_in = (cnt_ff == '0) ? mpk_pkg::ST_F_KX : mpk_pkg::ST_H_M1;
         end
         mpk_pkg::ST_H_M1: begin
            is_mul = 1'b1; mul_a = bx_ff; mul_b = x_ff;
            if (mul_done) state_in = mpk_pkg::ST_H_M2;
         end
         mpk_pkg::ST_H_M2: begin
            is_mul = 1'b1; mul_a = by_ff; mul_b = y_ff;
            if (mul_done) state_in = mpk_pkg::ST_H_M3;
         end
         mpk_pkg::ST_H_M3: begin
            is_mul = 1'b1; mul_a = bx_ff; mul_b = y_ff;
            if (mul_done) state_in = mpk_pkg::ST_H_M4;
         end
         mpk_pkg::ST_H_M4: begin
            is_mul = 1'b1; mul_a = by_ff; mul_b = x_ff;
            if (mul_done) state_in = mpk_pkg::ST_H_ADD1;
         end
         mpk_pkg::ST_H_ADD1: state_in = mpk_pkg::ST_H_ADD2;
         mpk_pkg::ST_H_ADD2: begin
            cell_shift = 1'b1;
            state_in = (cnt_ff == IW'(1)) ? mpk_pkg::ST_F_KX : mpk_pkg::ST_H_M1;
         end
         mpk_pkg::ST_F_KX: begin
            is_mul = 1'b1; mul_a = chi_ff; mul_b = bx_ff;
            if (mul_done) state_in = mpk_pkg::ST_F_KY;
         end
         mpk_pkg::ST_F_KY: begin
            is_mul = 1'b1; mul_a = chi_ff; mul_b = by_ff;
            if (mul_done) state_in = has_len ? mpk_pkg::ST_C_B1 : mpk_pkg::ST_OUT;
         end
         mpk_pkg::ST_C_B1: begin
            is_mul = 1'b1; mul_a = chi_ff; mul_b = stored[0].n;
            if (mul_done) state_in = mpk_pkg::ST_C_A1;
         end
         mpk_pkg::ST_C_A1: begin
            is_mul = 1'b1; mul_a = chi_ff; mul_b = stored[0].s;
            if (mul_done) state_in = mpk_pkg::ST_C_HXM;
         end
         mpk_pkg::ST_C_HXM: begin
            is_mul = 1'b1; mul_a = hxl_ff; mul_b = x_ff;
            if (mul_done) state_in = mpk_pkg::ST_C_HXD;
         end
         mpk_pkg::ST_C_HXD: begin
            is_div = 1'b1;
            if (div_done) state_in = mpk_pkg::ST_C_HYM;
         end
         mpk_pkg::ST_C_HYM: begin
            is_mul = 1'b1; mul_a = hyl_ff; mul_b = y_ff;
            if (mul_done) state_in = mpk_pkg::ST_C_HYD;
         end
         mpk_pkg::ST_C_HYD: begin
            is_div = 1'b1;
            if (div_done) state_in = mpk_pkg::ST_C_TXM1;
         end
         mpk_pkg::ST_C_TXM1: begin
            is_mul = 1'b1; mul_a = hxl_ff; mul_b = dl_ff;
            if (mul_done) state_in = mpk_pkg::ST_C_TXM2;
         end
         mpk_pkg::ST_C_TXM2: begin
            is_mul = 1'b1; mul_a = r1_ff; mul_b = hxx_ff;
            if (mul_done) state_in = mpk_pkg::ST_C_TXA;
         end
         mpk_pkg::ST_C_TXA: state_in = mpk_pkg::ST_C_TXB;
         mpk_pkg::ST_C_TXB: state_in = mpk_pkg::ST_C_TXC;
         mpk_pkg::ST_C_TXC: state_in = mpk_pkg::ST_C_TYM1;
         mpk_pkg::ST_C_TYM1: begin
            is_mul = 1'b1; mul_a = hyl_ff; mul_b = dl_ff;
            if (mul_done) state_in = mpk_pkg::ST_C_TYM2;
         end
         mpk_pkg::ST_C_TYM2: begin
            is_mul = 1'b1; mul_a = r2_ff; mul_b = hyy_ff;
            if (mul_done) state_in = mpk_pkg::ST_C_TYA;
         end
         mpk_pkg::ST_C_TYA: state_in = mpk_pkg::ST_C_TYB;
         mpk_pkg::ST_C_TYB: state_in = mpk_pkg::ST_C_TYC;
         mpk_pkg::ST_C_TYC: state_in = mpk_pkg::ST_S_D;
         mpk_pkg::ST_S_D:   state_in = mpk_pkg::ST_S_M1;
         mpk_pkg::ST_S_M1: begin
            is_mul = 1'b1; mul_a = chi_ff; mul_b = m1_ff;
            if (mul_done) state_in = mpk_pkg::ST_S_M2;
         end
         mpk_pkg::ST_S_M2: begin
            is_mul = 1'b1; mul_a = sig_ff; mul_b = len_val;
            if (mul_done) state_in = mpk_pkg::ST_S_M3;
         end
         mpk_pkg::ST_S_M3: begin
            is_mul = 1'b1; mul_a = sig_ff; mul_b = rvv_ff;
            if (mul_done) state_in = mpk_pkg::ST_OUT;
         end
         mpk_pkg::ST_OUT: begin
            if (!rsp_tvalid || rsp_tready) state_in = mpk_pkg::ST_IDLE;
         end
         default: state_in = mpk_pkg::ST_IDLE;
      endcase
   end

   assign mul_go = is_mul && !issued_ff;
   assign div_go = is_div && !issued_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mpk_pkg::ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // hold the unit started until its done pulse
         if ((is_mul && mul_done) || (is_div && div_done)) begin
            issued_ff <= 1'b0;
         end else if (is_mul || is_div) begin
            issued_ff <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         mpk_pkg::ST_IDLE: begin
            if (kick_acc) begin
               x_ff   <= req_tdata[O_X +: VW];
               y_ff   <= req_tdata[O_Y +: VW];
               dl_ff  <= req_tdata[O_DL +: VW];
               chi_ff <= req_tdata[O_CHI +: VW];
               rvv_ff <= req_tdata[O_RVV +: VW];
               id_ff  <= req_tdata[O_ID +: 16];
               ord_ff <= ord_clamp;
               cnt_ff <= ord_clamp;
               sig_ff <= '0;
            end
         end
         mpk_pkg::ST_LOAD: begin
            bx_ff <= tap.n;
            by_ff <= tap.s;
         end
         mpk_pkg::ST_H_M1: if (mul_done) m1_ff <= mul_res;
         mpk_pkg::ST_H_M2: if (mul_done) m2_ff <= mul_res;
         mpk_pkg::ST_H_M3: if (mul_done) m3_ff <= mul_res;
         mpk_pkg::ST_H_M4: if (mul_done) m4_ff <= mul_res;
         mpk_pkg::ST_H_ADD1: begin
            m1_ff <= mpk_pkg::ssub(m1_ff, m2_ff);
            m3_ff <= mpk_pkg::sadd(m3_ff, m4_ff);
         end
         mpk_pkg::ST_H_ADD2: begin
            bx_ff  <= mpk_pkg::sadd(tap.n, m1_ff);
            by_ff  <= mpk_pkg::sadd(tap.s, m3_ff);
            cnt_ff <= cnt_ff - 1'b1;
         end
         mpk_pkg::ST_F_KX:  if (mul_done) bx_ff <= mpk_pkg::sneg(mul_res);
         mpk_pkg::ST_F_KY:  if (mul_done) by_ff <= mul_res;
         mpk_pkg::ST_C_B1:  if (mul_done) r1_ff <= mul_res;
         mpk_pkg::ST_C_A1:  if (mul_done) r2_ff <= mul_res;
         mpk_pkg::ST_C_HXD: if (div_done) hxx_ff <= div_res;
         mpk_pkg::ST_C_HYD: if (div_done) hyy_ff <= div_res;
         mpk_pkg::ST_C_TXM1, mpk_pkg::ST_C_TYM1: if (mul_done) m1_ff <= mul_res;
         mpk_pkg::ST_C_TXM2, mpk_pkg::ST_C_TYM2: if (mul_done) m2_ff <= mul_res;
         mpk_pkg::ST_C_TXA: m1_ff <= mpk_pkg::sadd(hxl_ff, m1_ff);
         mpk_pkg::ST_C_TYA: m1_ff <= mpk_pkg::sadd(hyl_ff, m1_ff);
         mpk_pkg::ST_C_TXB, mpk_pkg::ST_C_TYB: m1_ff <= mpk_pkg::ssub(m1_ff, m2_ff);
         mpk_pkg::ST_C_TXC: bx_ff <= mpk_pkg::sadd(bx_ff, m1_ff);
         mpk_pkg::ST_C_TYC: by_ff <= mpk_pkg::ssub(by_ff, m1_ff);
         mpk_pkg::ST_S_D:   m1_ff <= mpk_pkg::ssub(hxx_ff, hyy_ff);
         mpk_pkg::ST_S_M1, mpk_pkg::ST_S_M2: if (mul_done) sig_ff <= mul_res;
         mpk_pkg::ST_S_M3:  if (mul_done) sig_ff <= mpk_pkg::sneg(mul_res);
         default: ;
      endcase
   end

   // output register: hold the result until taken
   logic         rsp_tvalid_ff;
   logic [159:0] rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (state_ff == mpk_pkg::ST_OUT && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == mpk_pkg::ST_OUT && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_tdata_ff <= {sig_ff, by_ff, bx_ff, id_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== rtl/mpk_cell.sv =====
// ----------------------------------------------------------------------------
// mpk_cell
// One coefficient cell: stores a normal/skew pair and a travel copy that
// moves one cell up per Horner step.
// ----------------------------------------------------------------------------
module mpk_cell (
   input  logic                  clock,
   input  logic                  wr_en,
   input  mpk_pkg::coef_pair_type wr_pair,
   input  logic                  load,
   input  logic                  shift,
   input  mpk_pkg::coef_pair_type travel_prev,
   output mpk_pkg::coef_pair_type stored,
   output mpk_pkg::coef_pair_type travel
);

   mpk_pkg::coef_pair_type stored_ff;
   mpk_pkg::coef_pair_type travel_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stored_ff <= wr_pair;
      end
      if (load) begin
         travel_ff <= stored_ff;
      end else if (shift) begin
         travel_ff <= travel_prev;
      end
   end

   assign stored = stored_ff;
   assign travel = travel_ff;

endmodule

// ===== rtl/mpk_mul.sv =====
// ----------------------------------------------------------------------------
// mpk_mul
// Signed Q16.32 multiplier: two half-width partial products in the LO and HI
// phases, exact product kept for the divider, saturated result.
// ----------------------------------------------------------------------------
module mpk_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  mpk_pkg::value_type         a,
   input  mpk_pkg::value_type         b,
   output logic                       done,
   output mpk_pkg::value_type         res,
   output logic [mpk_pkg::PW-1:0]     prod,
   output logic                       neg
);

   mpk_pkg::mul_phase_type phase_ff, phase_in;
   logic [mpk_pkg::VW-1:0] ma_ff, mb_ff;
   logic [mpk_pkg::PW-1:0] acc_ff;
   logic                   neg_ff;
   logic [mpk_pkg::VW+mpk_pkg::HW-1:0] part;
   logic                   big;

   always_comb begin
      part = (phase_ff == mpk_pkg::MUL_LO) ?
             ma_ff * mb_ff[mpk_pkg::HW-1:0] :
             ma_ff * mb_ff[mpk_pkg::VW-1:mpk_pkg::HW];
      unique case (phase_ff)
         mpk_pkg::MUL_IDLE: phase_in = go ? mpk_pkg::MUL_LO : mpk_pkg::MUL_IDLE;
         mpk_pkg::MUL_LO:   phase_in = mpk_pkg::MUL_HI;
         mpk_pkg::MUL_HI:   phase_in = mpk_pkg::MUL_DONE;
         mpk_pkg::MUL_DONE: phase_in = mpk_pkg::MUL_IDLE;
         default:           phase_in = mpk_pkg::MUL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mpk_pkg::MUL_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (phase_ff == mpk_pkg::MUL_IDLE && go) begin
         ma_ff  <= mpk_pkg::mag(a);
         mb_ff  <= mpk_pkg::mag(b);
         neg_ff <= a[mpk_pkg::VW-1] ^ b[mpk_pkg::VW-1];
      end
      if (phase_ff == mpk_pkg::MUL_LO) begin
         acc_ff <= mpk_pkg::PW'(part);
      end else if (phase_ff == mpk_pkg::MUL_HI) begin
         acc_ff <= acc_ff + {part, {mpk_pkg::HW{1'b0}}};
      end
   end

   // Drop the fraction bits; anything at or above the sign position saturates.
   assign big  = |acc_ff[mpk_pkg::PW-1:mpk_pkg::FRAC+mpk_pkg::VW-1];
   assign res  = mpk_pkg::sfinish(neg_ff, big,
                    acc_ff[mpk_pkg::FRAC+mpk_pkg::VW-1:mpk_pkg::FRAC]);
   assign done = (phase_ff == mpk_pkg::MUL_DONE);
   assign prod = acc_ff;
   assign neg  = neg_ff;

endmodule

// ===== rtl/mpk_div.sv =====
// ----------------------------------------------------------------------------
// mpk_div
// Restoring divider, one quotient bit per cycle: exact product over length,
// truncated toward zero, saturated.
// ----------------------------------------------------------------------------
module mpk_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic [mpk_pkg::PW-1:0] dividend,
   input  logic                   neg,
   input  logic [mpk_pkg::LW-1:0] divisor,
   output logic                   done,
   output mpk_pkg::value_type     res
);

   localparam int CW = $clog2(mpk_pkg::PW);

   logic [mpk_pkg::PW-1:0] dvd_ff;
   logic [mpk_pkg::VW-1:0] rem_ff, dvs_ff, q_ff;
   logic                   over_ff, neg_ff, busy_ff, done_ff;
   logic [CW-1:0]          cnt_ff;
   logic [mpk_pkg::VW:0]   rem2;
   logic                   ge;

   assign rem2 = {rem_ff, dvd_ff[mpk_pkg::PW-1]};
   assign ge   = (rem2 >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (go && !busy_ff) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go && !busy_ff) begin
         dvd_ff  <= dividend;
         dvs_ff  <= {1'b0, divisor};
         neg_ff  <= neg;
         rem_ff  <= '0;
         q_ff    <= '0;
         over_ff <= 1'b0;
         cnt_ff  <= CW'(mpk_pkg::PW - 1);
      end else if (busy_ff) begin
         rem_ff  <= ge ? mpk_pkg::VW'(rem2 - {1'b0, dvs_ff}) : rem2[mpk_pkg::VW-1:0];
         q_ff    <= {q_ff[mpk_pkg::VW-2:0], ge};
         over_ff <= over_ff | q_ff[mpk_pkg::VW-1];
         dvd_ff  <= {dvd_ff[mpk_pkg::PW-2:0], 1'b0};
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   assign done = done_ff;
   assign res  = mpk_pkg::sfinish(neg_ff, over_ff | q_ff[mpk_pkg::VW-1], q_ff);

endmodule

// ===== rtl/mpk_checker.sv =====
// ----------------------------------------------------------------------------
// mpk_checker
// Port-level checks of the multipole kick, bound to the top level.
// ----------------------------------------------------------------------------
module mpk_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [159:0] rsp_tdata
);

   // a stalled result holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a kick item keeps the input closed in the next cycle
   a_kick_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("input open right after a kick item");

   // a coefficient write leaves the input open in the next cycle
   a_write_fast: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> req_tready)
      else $error("input closed after a coefficient write");

   // a new result appears only while a kick is in work
   a_rsp_from_kick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without a kick in work");

endmodule

bind multipole_kick_horner mpk_checker u_mpk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/multipole_kick_horner_tb.sv =====
// ----------------------------------------------------------------------------
// multipole_kick_horner_tb
// Self-checking bench for the thin multipole kick: streams coefficient-write
// and kick items, predicts each kick in signed Q16.32 with saturation, and
// compares every result field by field, mostly under random idling on both sides.
// ----------------------------------------------------------------------------
module multipole_kick_horner_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef mpk_pkg::value_type value_type;

   localparam int TABLE_DEPTH = 16;
   localparam int SETTLE_CYCLES = 600;  // longer than the slowest kick

   typedef struct {
      logic       op;
      logic [3:0] idx;
      value_type  cn;
      value_type  cs;
      logic [15:0] id;
      value_type  x;
      value_type  y;
      value_type  dl;
      value_type  chi;
      value_type  rvv;
   } particle_item_type;

   typedef struct {
      logic [15:0] id;
      value_type   px;
      value_type   py;
      value_type   sig;
   } kick_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [359:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_addr = '0;
   logic [47:0]  csr_wdata = '0;

   // predictor state
   logic [3:0]  mdl_order = '0;
   logic [46:0] mdl_length = '0;
   value_type   mdl_hbend = '0;
   value_type   mdl_vbend = '0;
   value_type   mdl_norm [TABLE_DEPTH];
   value_type   mdl_skew [TABLE_DEPTH];

   particle_item_type pending_items[$];
   particle_item_type cur_item;
   kick_result_type   expected_kicks[$];
   int unsigned    issued_count = 0;
   int unsigned    accepted_count = 0;
   int unsigned    error_count = 0;
   int unsigned    req_gap = 0;
   int unsigned    rsp_gap = 0;
   bit             quiet = 1'b0;    // no idling at all
   bit             calm = 1'b0;     // a stretch without idling

   multipole_kick_horner u_dut (.*);

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // Fixed-point arithmetic of the kick, saturating to 48 bits
   // ------------------------------------------------------------------------
   function automatic value_type sat_sum(value_type a, value_type b, bit sub);
      logic signed [49:0] r;
      r = sub ? (50'(a) - 50'(b)) : (50'(a) + 50'(b));
      if (r > 50'sh7FFF_FFFF_FFFF) return value_type'(mpk_pkg::VMAX);
      if (r < -50'sh8000_0000_0000) return value_type'(mpk_pkg::VMIN);
      return r[47:0];
   endfunction

   function automatic value_type sat_negate(value_type a);
      return (a == value_type'(mpk_pkg::VMIN)) ? value_type'(mpk_pkg::VMAX) : -a;
   endfunction

   function automatic logic [127:0] abs_wide(value_type a);
      logic [47:0] m;
      m = a[47] ? 48'(-a) : 48'(a);
      return {80'b0, m};
   endfunction

   // Sign a truncated magnitude and clip it to the value range.
   function automatic value_type signed_clip(bit neg, logic [127:0] q);
      if (neg) begin
         if (q >= 128'h8000_0000_0000) return value_type'(mpk_pkg::VMIN);
         return -value_type'(q[47:0]);
      end
      if (q > 128'h7FFF_FFFF_FFFF) return value_type'(mpk_pkg::VMAX);
      return value_type'(q[47:0]);
   endfunction

   function automatic value_type q_mul(value_type a, value_type b);
      logic [127:0] p;
      p = abs_wide(a) * abs_wide(b);
      return signed_clip(a[47] != b[47], p >> 32);
   endfunction

   function automatic value_type q_muldiv(value_type a, value_type b, logic [46:0] d);
      logic [127:0] p;
      p = abs_wide(a) * abs_wide(b);
      return signed_clip(a[47] != b[47], p / {81'b0, d});
   endfunction

   function automatic kick_result_type kick_of(particle_item_type it);
      kick_result_type r;
      value_type bx, by, zre, zim, b1l, a1l, hxx, hyy, tx, ty, sg;
      bx = mdl_norm[mdl_order];
      by = mdl_skew[mdl_order];
      for (int k = int'(mdl_order) - 1; k >= 0; k--) begin
         zre = sat_sum(q_mul(bx, it.x), q_mul(by, it.y), 1);
         zim = sat_sum(q_mul(bx, it.y), q_mul(by, it.x), 0);
         bx = sat_sum(mdl_norm[k], zre, 0);
         by = sat_sum(mdl_skew[k], zim, 0);
      end
      bx = sat_negate(q_mul(it.chi, bx));
      by = q_mul(it.chi, by);
      sg = '0;
      if (mdl_length != 0) begin
         b1l = q_mul(it.chi, mdl_norm[0]);
         a1l = q_mul(it.chi, mdl_skew[0]);
         hxx = q_muldiv(mdl_hbend, it.x, mdl_length);
         hyy = q_muldiv(mdl_vbend, it.y, mdl_length);
         tx = sat_sum(sat_sum(mdl_hbend, q_mul(mdl_hbend, it.dl), 0), q_mul(b1l, hxx), 1);
         ty = sat_sum(sat_sum(mdl_vbend, q_mul(mdl_vbend, it.dl), 0), q_mul(a1l, hyy), 1);
         bx = sat_sum(bx, tx, 0);
         by = sat_sum(by, ty, 1);
         sg = q_mul(it.chi, sat_sum(hxx, hyy, 1));
         sg = q_mul(sg, value_type'({1'b0, mdl_length}));
         sg = sat_negate(q_mul(sg, it.rvv));
      end
      r.id = it.id;
      r.px = bx;
      r.py = by;
      r.sig = sg;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: present items at the falling edge, idle in bursts
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (issued_count == accepted_count) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            cur_item = pending_items.pop_front();
            req_tuser <= cur_item.op;
            req_tdata <= {4'b0, cur_item.rvv, cur_item.chi, cur_item.dl, cur_item.y,
                          cur_item.x, cur_item.id, cur_item.cs, cur_item.cn, cur_item.idx};
            req_tvalid <= 1'b1;
            issued_count = issued_count + 1;
            if (!quiet && !calm && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 5);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side backpressure, also in bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap = rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && !calm && $urandom_range(0, 3) == 0) rsp_gap = $urandom_range(1, 5);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on each accepted item, check each accepted result
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      kick_result_type exp_r, got;
      if (!reset && req_tvalid && req_tready) begin
         accepted_count = accepted_count + 1;
         if (cur_item.op == mpk_pkg::OP_WRITE) begin
            mdl_norm[cur_item.idx] = cur_item.cn;
            mdl_skew[cur_item.idx] = cur_item.cs;
         end else begin
            expected_kicks.push_back(kick_of(cur_item));
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.id = rsp_tdata[15:0];
         got.px = rsp_tdata[63:16];
         got.py = rsp_tdata[111:64];
         got.sig = rsp_tdata[159:112];
         if (expected_kicks.size() == 0) begin
            $display("%0t: unexpected result id %h", $realtime, got.id);
            error_count++;
         end else begin
            exp_r = expected_kicks.pop_front();
            if (got.id !== exp_r.id) begin
               $display("%0t: out_id expected %h actual %h", $realtime, exp_r.id, got.id);
               error_count++;
            end
            if (got.px !== exp_r.px) begin
               $display("%0t: kick_px expected %h actual %h", $realtime, exp_r.px, got.px);
               error_count++;
            end
            if (got.py !== exp_r.py) begin
               $display("%0t: kick_py expected %h actual %h", $realtime, exp_r.py, got.py);
               error_count++;
            end
            if (got.sig !== exp_r.sig) begin
               $display("%0t: sigma_change expected %h actual %h",
                        $realtime, exp_r.sig, got.sig);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // Mix full-range, moderate and extreme values so saturation is not constant.
   function automatic value_type rnd_q();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return value_type'(mpk_pkg::VMAX);
         1:       return value_type'(mpk_pkg::VMIN);
         2, 3:    return r[47:0];
         default: return value_type'($signed(r[34:0]));  // within about +-4.0
      endcase
   endfunction

   function automatic particle_item_type rnd_item();
      particle_item_type it;
      it.op = ($urandom_range(0, 3) == 0) ? mpk_pkg::OP_WRITE : mpk_pkg::OP_KICK;
      it.idx = 4'($urandom_range(0, 15));
      it.cn = rnd_q();
      it.cs = rnd_q();
      it.id = 16'($urandom_range(0, 65535));
      it.x = rnd_q();
      it.y = rnd_q();
      it.dl = rnd_q();
      it.chi = rnd_q();
      it.rvv = rnd_q();
      return it;
   endfunction

   function automatic particle_item_type kick_item(logic [15:0] id, value_type x,
                                                   value_type y, value_type dl,
                                                   value_type chi, value_type rvv);
      particle_item_type it;
      it = rnd_item();
      it.op = mpk_pkg::OP_KICK;
      it.id = id;
      it.x = x;
      it.y = y;
      it.dl = dl;
      it.chi = chi;
      it.rvv = rvv;
      return it;
   endfunction

   task automatic csr_write(mpk_pkg::csr_index_type addr, logic [47:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = addr;
      csr_wdata = data;
      case (addr)
         mpk_pkg::CSR_ORDER:  mdl_order = data[3:0];
         mpk_pkg::CSR_LENGTH: mdl_length = data[46:0];
         mpk_pkg::CSR_HBEND:  mdl_hbend = data;
         default:             mdl_vbend = data;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_lattice(logic [47:0] order, logic [47:0] len,
                              logic [47:0] hb, logic [47:0] vb);
      csr_write(mpk_pkg::CSR_ORDER, order);
      csr_write(mpk_pkg::CSR_LENGTH, len);
      csr_write(mpk_pkg::CSR_HBEND, hb);
      csr_write(mpk_pkg::CSR_VBEND, vb);
   endtask

   // Hold until every expected result is back and the block is quiet.
   task automatic drain();
      @(posedge clock);
      while (pending_items.size() > 0 || issued_count != accepted_count ||
             expected_kicks.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      particle_item_type it;
      logic [47:0] len;
      int n_items;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: fill the whole table first so no entry is read unwritten.
      set_lattice(48'd15, 48'h0001_0000_0000, 48'h0000_8000_0000, 48'hFFFF_C000_0000);
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         it = rnd_item();
         it.op = mpk_pkg::OP_WRITE;
         it.idx = 4'(k);
         it.cn = (k == 0) ? value_type'(mpk_pkg::VMAX) :
                 (k == 15) ? value_type'(mpk_pkg::VMIN) : rnd_q();
         it.cs = (k == 0) ? value_type'(mpk_pkg::VMIN) :
                 (k == 15) ? value_type'(mpk_pkg::VMAX) : rnd_q();
         pending_items.push_back(it);
      end
      pending_items.push_back(kick_item(16'h0000, '0, '0, '0, '0, '0));
      pending_items.push_back(kick_item(16'hFFFF, value_type'(mpk_pkg::VMAX),
                              value_type'(mpk_pkg::VMAX), value_type'(mpk_pkg::VMAX),
                              value_type'(mpk_pkg::VMAX), value_type'(mpk_pkg::VMAX)));
      pending_items.push_back(kick_item(16'hA5A5, value_type'(mpk_pkg::VMIN),
                              value_type'(mpk_pkg::VMIN), value_type'(mpk_pkg::VMIN),
                              value_type'(mpk_pkg::VMIN), value_type'(mpk_pkg::VMIN)));
      pending_items.push_back(kick_item(16'h5A5A, 48'h0000_4000_0000, 48'hFFFF_C000_0000,
                              48'h0000_0010_0000, value_type'(mpk_pkg::VMIN),
                              48'h0001_0000_0000));
      pending_items.push_back(kick_item(16'h1234, 48'h0000_1000_0000, 48'h0000_2000_0000,
                              '0, 48'h0001_0000_0000, 48'h0001_0000_0000));
      drain();

      // Order zero, zero length: plain dipole with no sigma change.
      set_lattice(48'd0, 48'd0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
      pending_items.push_back(kick_item(16'h0F0F, value_type'(mpk_pkg::VMAX),
                              value_type'(mpk_pkg::VMIN), rnd_q(),
                              value_type'(mpk_pkg::VMIN), rnd_q()));
      pending_items.push_back(kick_item(16'hF0F0, rnd_q(), rnd_q(), rnd_q(),
                              48'h0001_0000_0000, rnd_q()));
      drain();

      // Random phases over a range of lattice settings, extremes included.
      for (int ph = 0; ph < 10; ph++) begin
         calm = ($urandom_range(0, 3) == 0);
         quiet = (ph == 9);
         case (ph)
            0: len = 48'h7FFF_FFFF_FFFF;                     // longest element
            1: len = 48'd1;                                  // shortest element
            2, 5: len = 48'd0;
            default: len = 48'({$urandom, $urandom}) & 48'h00FF_FFFF_FFFF;
         endcase
         set_lattice((ph == 3) ? 48'd15 : (ph == 4) ? 48'd0 : 48'($urandom_range(0, 3)),
                     len,
                     (ph == 0) ? 48'h8000_0000_0000 : 48'({$urandom, $urandom}),
                     (ph == 0) ? 48'h7FFF_FFFF_FFFF : 48'({$urandom, $urandom}));
         n_items = (ph == 3) ? 40 : 120;
         for (int i = 0; i < n_items; i++) pending_items.push_back(rnd_item());
         drain();
      end

      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== multipole_kick_horner.f =====
rtl/mpk_pkg.sv
rtl/mpk_cell.sv
rtl/mpk_mul.sv
rtl/mpk_div.sv
rtl/multipole_kick_horner.sv
rtl/mpk_checker.sv
dv/multipole_kick_horner_tb.sv
